@@ src/assert_macros.svh @@
// Assertion macros shared by the unescaper RTL.
// Depends on signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ src/jsu_pkg.sv @@
// Package of the JSON string unescaper: status codes, queue entry type, UTF-8 helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   localparam logic [2:0] ST_DATA   = 3'd0;
   localparam logic [2:0] ST_END    = 3'd1;
   localparam logic [2:0] ST_UNTERM = 3'd2;
   localparam logic [2:0] ST_BADESC = 3'd3;
   localparam logic [2:0] ST_BADHEX = 3'd4;

   localparam int JSU_QUEUE_DEPTH = 4;

   // one queue entry: optional EF BF BD prefix, then up to four tail results
   typedef struct packed {
      logic            rep_prefix;
      logic [2:0]      tail_count;
      logic [2:0]      tail_status;
      logic [3:0][7:0] tail_byte;
   } jsu_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jsu_qstat_type;

   function automatic logic [7:0] jsu_rep_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'hEF;
         2'd1:    b = 8'hBF;
         default: b = 8'hBD;
      endcase
      return b;
   endfunction

   // {ok, value}
   function automatic logic [4:0] jsu_hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // {ok, byte} for the single-character escapes
   function automatic logic [8:0] jsu_escape_map(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic jsu_desc_type jsu_encode16(input logic [15:0] v, input logic prefix);
      jsu_desc_type d;
      d = '0;
      d.rep_prefix  = prefix;
      d.tail_status = ST_DATA;
      if (v <= 16'h007F) begin
         d.tail_count   = 3'd1;
         d.tail_byte[0] = v[7:0];
      end else if (v <= 16'h07FF) begin
         d.tail_count   = 3'd2;
         d.tail_byte[0] = {3'b110, v[10:6]};
         d.tail_byte[1] = {2'b10, v[5:0]};
      end else begin
         d.tail_count   = 3'd3;
         d.tail_byte[0] = {4'b1110, v[15:12]};
         d.tail_byte[1] = {2'b10, v[11:6]};
         d.tail_byte[2] = {2'b10, v[5:0]};
      end
      return d;
   endfunction

   function automatic jsu_desc_type jsu_encode_pair(input logic [9:0] hi, input logic [9:0] lo);
      jsu_desc_type d;
      logic [20:0]  cp;
      d  = '0;
      cp = 21'h10000 | {1'b0, hi, 10'b0} | {11'b0, lo};
      d.tail_status  = ST_DATA;
      d.tail_count   = 3'd4;
      d.tail_byte[0] = {5'b11110, cp[20:18]};
      d.tail_byte[1] = {2'b10, cp[17:12]};
      d.tail_byte[2] = {2'b10, cp[11:6]};
      d.tail_byte[3] = {2'b10, cp[5:0]};
      return d;
   endfunction

   function automatic jsu_desc_type jsu_replacement(input logic prefix);
      jsu_desc_type d;
      d = '0;
      d.rep_prefix   = prefix;
      d.tail_status  = ST_DATA;
      d.tail_count   = 3'd3;
      d.tail_byte[0] = 8'hEF;
      d.tail_byte[1] = 8'hBF;
      d.tail_byte[2] = 8'hBD;
      return d;
   endfunction

endpackage

`default_nettype wire

@@ src/jsu_if.sv @@
// Valid/ready channel interfaces for the unescaper: input bytes and result bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;
   modport source (output valid, in_byte, end_of_text, input ready);
   modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic       last;
   modport source (output valid, out_byte, status, last, input ready);
   modport sink (input valid, out_byte, status, last, output ready);
endinterface

`default_nettype wire

@@ src/jsu_front.sv @@
// Front end of the unescaper: accepts bytes, tracks escape state, queues result groups.
// Depends on jsu_pkg and jsu_req_if.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front import jsu_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   jsu_req_if.sink            req,
   input  wire jsu_qstat_type q_stat,
   output logic               q_push,
   output jsu_desc_type       q_desc
);

   localparam logic [2:0] PH_TEXT    = 3'd0;
   localparam logic [2:0] PH_ESC     = 3'd1;
   localparam logic [2:0] PH_HEX     = 3'd2;
   localparam logic [2:0] PH_HIGH    = 3'd3;
   localparam logic [2:0] PH_HIGH_BS = 3'd4;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] hex_value_ff, hex_value_in;
   logic        hex_invalid_ff, hex_invalid_in;
   logic [9:0]  pending_ff, pending_in;
   logic        second_ff, second_in;

   logic        accept;
   logic        eot;
   logic [7:0]  c;
   logic [4:0]  dig;
   logic [8:0]  esc;
   logic [15:0] nv;
   logic        ninv;
   logic        text_go;
   logic        esc_go;
   logic        clear_go;
   jsu_desc_type desc;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign eot       = req.end_of_text;
   assign c         = req.in_byte;
   assign dig       = jsu_hex_digit(c);
   assign esc       = jsu_escape_map(c);
   assign nv        = dig[4] ? {hex_value_ff[11:0], dig[3:0]} : hex_value_ff;
   assign ninv      = hex_invalid_ff | !dig[4];

   always_comb begin
      phase_in       = phase_ff;
      hex_count_in   = hex_count_ff;
      hex_value_in   = hex_value_ff;
      hex_invalid_in = hex_invalid_ff;
      pending_in     = pending_ff;
      second_in      = second_ff;
      desc           = '0;
      text_go        = 1'b0;
      esc_go         = 1'b0;
      clear_go       = 1'b0;

      case (phase_ff)
         PH_ESC: begin
            esc_go = 1'b1;
         end
         PH_HEX: begin
            if (eot) begin
               desc.tail_count  = 3'd1;
               desc.tail_status = ST_BADHEX;
               clear_go         = 1'b1;
            end else if (hex_count_ff != 2'd3) begin
               hex_count_in   = hex_count_ff + 2'd1;
               hex_value_in   = nv;
               hex_invalid_in = ninv;
            end else if (ninv) begin
               desc.tail_count  = 3'd1;
               desc.tail_status = ST_BADHEX;
               clear_go         = 1'b1;
            end else begin
               hex_count_in   = '0;
               hex_value_in   = '0;
               hex_invalid_in = 1'b0;
               second_in      = 1'b0;
               pending_in     = '0;
               if (second_ff && nv[15:10] == 6'b110111) begin
                  desc     = jsu_encode_pair(pending_ff, nv[9:0]);
                  phase_in = PH_TEXT;
               end else if (nv[15:11] != 5'b11011) begin
                  desc     = jsu_encode16(nv, second_ff);
                  phase_in = PH_TEXT;
               end else if (nv[10]) begin
                  desc     = jsu_replacement(second_ff);
                  phase_in = PH_TEXT;
               end else begin
                  desc.rep_prefix = second_ff;
                  pending_in      = nv[9:0];
                  phase_in        = PH_HIGH;
               end
            end
         end
         PH_HIGH: begin
            if (!eot && c == CH_BSLASH) begin
               phase_in = PH_HIGH_BS;
            end else begin
               desc.rep_prefix = 1'b1;
               pending_in      = '0;
               phase_in        = PH_TEXT;
               text_go         = 1'b1;
            end
         end
         PH_HIGH_BS: begin
            if (!eot && c == CH_U) begin
               phase_in       = PH_HEX;
               hex_count_in   = '0;
               hex_value_in   = '0;
               hex_invalid_in = 1'b0;
               second_in      = 1'b1;
            end else begin
               desc.rep_prefix = 1'b1;
               pending_in      = '0;
               phase_in        = PH_ESC;
               esc_go          = 1'b1;
            end
         end
         default: begin
            phase_in = PH_TEXT;
            text_go  = 1'b1;
         end
      endcase

      if (text_go) begin
         if (eot || c == 8'h00) begin
            desc.tail_count  = 3'd1;
            desc.tail_status = ST_UNTERM;
            clear_go         = 1'b1;
         end else if (c == CH_QUOTE) begin
            desc.tail_count  = 3'd1;
            desc.tail_status = ST_END;
            clear_go         = 1'b1;
         end else if (c == CH_BSLASH) begin
            phase_in = PH_ESC;
         end else begin
            desc.tail_count   = 3'd1;
            desc.tail_byte[0] = c;
         end
      end

      if (esc_go) begin
         if (eot) begin
            desc.tail_count  = 3'd1;
            desc.tail_status = ST_BADESC;
            clear_go         = 1'b1;
         end else if (c == CH_U) begin
            phase_in       = PH_HEX;
            hex_count_in   = '0;
            hex_value_in   = '0;
            hex_invalid_in = 1'b0;
            second_in      = 1'b0;
         end else if (esc[8]) begin
            desc.tail_count   = 3'd1;
            desc.tail_byte[0] = esc[7:0];
            phase_in          = PH_TEXT;
         end else begin
            desc.tail_count  = 3'd1;
            desc.tail_status = ST_BADESC;
            clear_go         = 1'b1;
         end
      end

      if (clear_go) begin
         phase_in       = PH_TEXT;
         hex_count_in   = '0;
         hex_value_in   = '0;
         hex_invalid_in = 1'b0;
         pending_in     = '0;
         second_in      = 1'b0;
      end
   end

   assign q_push = accept && (desc.rep_prefix || desc.tail_count != 3'd0);
   assign q_desc = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TEXT;
         hex_count_ff   <= '0;
         hex_value_ff   <= '0;
         hex_invalid_ff <= 1'b0;
         pending_ff     <= '0;
         second_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         hex_count_ff   <= hex_count_in;
         hex_value_ff   <= hex_value_in;
         hex_invalid_ff <= hex_invalid_in;
         pending_ff     <= pending_in;
         second_ff      <= second_in;
      end
   end

endmodule

`default_nettype wire

@@ src/jsu_queue.sv @@
// Descriptor queue between front and back of the unescaper.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue import jsu_pkg::*; #(
   parameter int DEPTH = JSU_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire jsu_desc_type push_desc,
   input  wire logic         pop,
   output jsu_desc_type      head,
   output jsu_qstat_type     stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

@@ src/jsu_back.sv @@
// Back end of the unescaper: expands queued groups into result bytes, one per transfer.
// Depends on jsu_pkg and jsu_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back import jsu_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire jsu_desc_type  head,
   input  wire jsu_qstat_type q_stat,
   output logic               pop,
   jsu_rsp_if.source          rsp
);

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] status_ff, status_in;
   logic       last_ff, last_in;

   logic [2:0] base;
   logic [2:0] total;
   logic [2:0] tidx;
   logic       is_rep;
   logic       out_free;

   assign base     = head.rep_prefix ? 3'd3 : 3'd0;
   assign total    = base + head.tail_count;
   assign tidx     = step_ff - base;
   assign is_rep   = head.rep_prefix && (step_ff < 3'd3);
   assign out_free = !valid_ff || rsp.ready;
   assign last_in  = (step_ff == total - 3'd1);
   assign pop      = out_free && !q_stat.empty && last_in;

   always_comb begin
      valid_in  = valid_ff;
      step_in   = step_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      if (out_free) begin
         valid_in = !q_stat.empty;
         if (!q_stat.empty) begin
            step_in = last_in ? 3'd0 : step_ff + 3'd1;
            if (is_rep) begin
               byte_in   = jsu_rep_byte(step_ff[1:0]);
               status_in = ST_DATA;
            end else begin
               byte_in   = (head.tail_status == ST_DATA) ? head.tail_byte[tidx[1:0]] : 8'h00;
               status_in = head.tail_status;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && !q_stat.empty) begin
         byte_ff   <= byte_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.status   = status_ff;
   assign rsp.last     = last_ff;

endmodule

`default_nettype wire

@@ src/json_string_unescape_utf8_top.sv @@
// JSON string body unescaper to UTF-8, a byte a cycle in while its queue has room, a byte a
// cycle out while the receiver is ready. The front end takes one input byte per cycle whenever
// its queue of result groups has room; each byte yields zero to six result bytes, which the back
// end sends one per transfer from an output register once their group is registered in the
// queue. Input runs at one byte per cycle while the result stream keeps up; a byte that expands
// to several results holds the output for one transfer each, and the QUEUE_DEPTH-entry queue
// absorbs those bursts. Errors and string end return the front end to its reset state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module json_string_unescape_utf8_top import jsu_pkg::*; #(
   parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   jsu_req_if.sink   req_ch,
   jsu_rsp_if.source rsp_ch
);

   logic          q_push;
   logic          q_pop;
   jsu_desc_type  q_desc;
   jsu_desc_type  q_head;
   jsu_qstat_type q_stat;

   jsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_desc (q_desc)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   jsu_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .q_stat (q_stat),
      .pop    (q_pop),
      .rsp    (rsp_ch)
   );

   `JSU_ASSERT_IMP(a_push_room, q_push, !q_stat.full, "push into a full queue")
   `JSU_ASSERT_IMP(a_pop_data, q_pop, !q_stat.empty, "pop from an empty queue")
   `JSU_ASSERT_IMP(a_status_last, rsp_ch.valid && rsp_ch.status != ST_DATA, rsp_ch.last && rsp_ch.out_byte == 8'h00, "status result not last or nonzero byte")
   `JSU_ASSERT_NEXT(a_idle_out, q_stat.empty && !q_push && (!rsp_ch.valid || rsp_ch.ready), !rsp_ch.valid, "result shown with nothing queued")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench of json_string_unescape_utf8_top: streams JSON string bodies,
// predicts the UTF-8 result bytes and statuses, and checks every result transfer.
// Depends on src/jsu_pkg.sv, src/jsu_if.sv and the RTL of the top level.
`timescale 1ns / 1ps

module testbench import jsu_pkg::*; ();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 137;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_DIGIT0 = 8'h30;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] NUL       = 8'h00;

   typedef enum logic [2:0] {
      PH_TEXT,
      PH_ESC,
      PH_HEX,
      PH_HIGH,
      PH_HIGH_BS
   } scan_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       last;
   } utf8_result_type;

   // {ok, nibble}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9) begin
         r = {1'b1, 4'(c - CH_DIGIT0)};
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) begin
         r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) begin
         r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
      end
      return r;
   endfunction

   class unescape_scoreboard;
      scan_phase_type  phase;
      logic [2:0]      hex_count;
      logic [15:0]     hex_value;
      logic            hex_invalid;
      logic [15:0]     pending_high;
      logic            second_escape;
      utf8_result_type expected_bytes[$];
      utf8_result_type burst[$];
      int              errors = 0;
      int              inputs_seen = 0;
      int              results_seen = 0;
      int              status_seen[5];

      function new();
         clear_state();
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void clear_state();
         phase         = PH_TEXT;
         hex_count     = '0;
         hex_value     = '0;
         hex_invalid   = 1'b0;
         pending_high  = '0;
         second_escape = 1'b0;
      endfunction

      function void put(input logic [7:0] b, input logic [2:0] st);
         utf8_result_type r;
         if (burst.size() < 6) begin
            r.out_byte = (st == ST_DATA) ? b : 8'h00;
            r.status   = st;
            r.last     = 1'b0;
            burst.insert(burst.size(), r);
         end
      endfunction

      function void put_replacement();
         put(8'hEF, ST_DATA);
         put(8'hBF, ST_DATA);
         put(8'hBD, ST_DATA);
      endfunction

      function void encode(input logic [20:0] cp);
         if (cp <= 21'h7F) begin
            put(cp[7:0], ST_DATA);
         end else if (cp <= 21'h7FF) begin
            put({3'b110, cp[10:6]}, ST_DATA);
            put({2'b10, cp[5:0]}, ST_DATA);
         end else if (cp <= 21'hFFFF) begin
            put({4'b1110, cp[15:12]}, ST_DATA);
            put({2'b10, cp[11:6]}, ST_DATA);
            put({2'b10, cp[5:0]}, ST_DATA);
         end else begin
            put({5'b11110, cp[20:18]}, ST_DATA);
            put({2'b10, cp[17:12]}, ST_DATA);
            put({2'b10, cp[11:6]}, ST_DATA);
            put({2'b10, cp[5:0]}, ST_DATA);
         end
      endfunction

      function void start_hex(input logic second);
         phase         = PH_HEX;
         hex_count     = '0;
         hex_value     = '0;
         hex_invalid   = 1'b0;
         second_escape = second;
      endfunction

      function void resolve(input logic [15:0] v);
         second_escape = 1'b0;
         if (v < 16'hD800 || v >= 16'hE000) begin
            encode({5'b0, v});
            phase = PH_TEXT;
         end else if (v >= 16'hDC00) begin
            put_replacement();
            phase = PH_TEXT;
         end else begin
            pending_high = v;
            phase        = PH_HIGH;
         end
      endfunction

      function void text_byte(input logic [7:0] c, input logic eot);
         if (eot || c == NUL) begin
            put(8'h00, ST_UNTERM);
            clear_state();
         end else if (c == CH_QUOTE) begin
            put(8'h00, ST_END);
            clear_state();
         end else if (c == CH_BSLASH) begin
            phase = PH_ESC;
         end else begin
            put(c, ST_DATA);
         end
      endfunction

      function void escape_byte(input logic [7:0] c, input logic eot);
         logic [7:0] v;
         logic       ok;
         ok = 1'b1;
         v  = c;
         if (eot) begin
            ok = 1'b0;
         end else if (c == CH_U) begin
            start_hex(1'b0);
            return;
         end else begin
            case (c)
               CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
               CH_B:    v = 8'h08;
               CH_F:    v = 8'h0C;
               CH_N:    v = 8'h0A;
               CH_R:    v = 8'h0D;
               CH_T:    v = 8'h09;
               default: ok = 1'b0;
            endcase
         end
         if (!ok) begin
            put(8'h00, ST_BADESC);
            clear_state();
         end else begin
            put(v, ST_DATA);
            phase = PH_TEXT;
         end
      endfunction

      function void hex_byte(input logic [7:0] c, input logic eot);
         logic [4:0]  d;
         logic [15:0] v;
         if (eot) begin
            put(8'h00, ST_BADHEX);
            clear_state();
            return;
         end
         d = hex_nibble(c);
         if (!d[4]) begin
            hex_invalid = 1'b1;
         end else begin
            hex_value = {hex_value[11:0], d[3:0]};
         end
         hex_count = hex_count + 3'd1;
         if (hex_count < 3'd4) return;
         if (hex_invalid) begin
            put(8'h00, ST_BADHEX);
            clear_state();
            return;
         end
         v         = hex_value;
         hex_count = '0;
         hex_value = '0;
         if (second_escape) begin
            if (v >= 16'hDC00 && v < 16'hE000) begin
               encode(21'h10000 | {1'b0, pending_high[9:0], v[9:0]});
               phase         = PH_TEXT;
               second_escape = 1'b0;
               pending_high  = '0;
               return;
            end
            put_replacement();
         end
         pending_high = '0;
         resolve(v);
      endfunction

      function void note_input(input logic [7:0] c, input logic eot);
         burst.delete();
         inputs_seen++;
         case (phase)
            PH_ESC: escape_byte(c, eot);
            PH_HEX: hex_byte(c, eot);
            PH_HIGH: begin
               if (!eot && c == CH_BSLASH) begin
                  phase = PH_HIGH_BS;
               end else begin
                  put_replacement();
                  pending_high = '0;
                  phase        = PH_TEXT;
                  text_byte(c, eot);
               end
            end
            PH_HIGH_BS: begin
               if (!eot && c == CH_U) begin
                  start_hex(1'b1);
               end else begin
                  put_replacement();
                  pending_high = '0;
                  phase        = PH_ESC;
                  escape_byte(c, eot);
               end
            end
            default: begin
               phase = PH_TEXT;
               text_byte(c, eot);
            end
         endcase
         if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) expected_bytes.insert(expected_bytes.size(), burst[i]);
      endfunction

      function void check_result(input utf8_result_type act);
         utf8_result_type exp_r;
         results_seen++;
         if (act.status < 3'd5) status_seen[act.status]++;
         if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result byte=%h status=%0d last=%b", $time,
                     act.out_byte, act.status, act.last);
            return;
         end
         exp_r = expected_bytes.pop_front();
         if (act.out_byte !== exp_r.out_byte || act.status !== exp_r.status ||
             act.last !== exp_r.last) begin
            errors++;
            $display("%0t: expected byte=%h status=%0d last=%b, got byte=%h status=%0d last=%b",
                     $time, exp_r.out_byte, exp_r.status, exp_r.last,
                     act.out_byte, act.status, act.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle = 16;
   int   recv_idle = 77;
   int   items_sent = 0;
   int   cycle_count = 0;
   unescape_scoreboard sb = new();

   jsu_req_if req_if();
   jsu_rsp_if rsp_if();

   json_string_unescape_utf8_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("json_string_unescape_utf8_top test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_input(req_if.in_byte, req_if.end_of_text);
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_result({rsp_if.out_byte, rsp_if.status, rsp_if.last});
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle);
   end

   // hold the byte until the transfer
   task automatic send_item(input logic [7:0] b, input logic eot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid       <= 1'b0;
         req_if.in_byte     <= 8'($urandom);
         req_if.end_of_text <= 1'($urandom);
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.in_byte     <= b;
      req_if.end_of_text <= eot;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CH_DIGIT0 + 8'(n);
      return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255, 1)); while (c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 5'h10);
      return c;
   endfunction

   function automatic logic [7:0] escape_letter();
      case ($urandom_range(7))
         0: return CH_QUOTE;
         1: return CH_BSLASH;
         2: return CH_SLASH;
         3: return CH_B;
         4: return CH_F;
         5: return CH_N;
         6: return CH_R;
         default: return CH_T;
      endcase
   endfunction

   function automatic logic [7:0] bad_letter();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B || c == CH_F ||
             c == CH_N || c == CH_R || c == CH_T || c == CH_U);
      return c;
   endfunction

   function automatic logic [15:0] rand_bmp();
      case ($urandom_range(3))
         0: return 16'($urandom_range(16'h007F));
         1: return 16'($urandom_range(16'h07FF, 16'h0080));
         2: return 16'($urandom_range(16'hD7FF, 16'h0800));
         default: return 16'($urandom_range(16'hFFFF, 16'hE000));
      endcase
   endfunction

   function automatic logic [15:0] rand_lead();
      return 16'($urandom_range(16'hDBFF, 16'hD800));
   endfunction

   function automatic logic [15:0] rand_trail();
      return 16'($urandom_range(16'hDFFF, 16'hDC00));
   endfunction

   task automatic send_u(input logic [15:0] v);
      send_item(CH_BSLASH, 1'b0);
      send_item(CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) send_item(hex_char(v[4 * i +: 4]), 1'b0);
   endtask

   task automatic send_element();
      int r;
      r = $urandom_range(99);
      if (r < 40) begin
         send_item(plain_byte(), 1'b0);
      end else if (r < 60) begin
         send_item(CH_BSLASH, 1'b0);
         send_item(escape_letter(), 1'b0);
      end else if (r < 80) begin
         send_u(rand_bmp());
      end else begin
         send_u(rand_lead());
         send_u(rand_trail());
      end
   endtask

   task automatic send_segment();
      logic [7:0] c;
      int         n;
      int         bad_pos;
      if ($urandom_range(99) < 60) begin
         n = $urandom_range(6);
         repeat (n) send_element();
         send_item(CH_QUOTE, 1'b0);
         return;
      end
      case ($urandom_range(9))
         0: send_u(rand_trail());
         1: begin
            send_u(rand_lead());
            do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
            send_item(c, $urandom_range(9) == 0);
         end
         2: begin
            send_u(rand_lead());
            send_item(CH_BSLASH, 1'b0);
            if ($urandom_range(1)) c = escape_letter();
            else c = bad_letter();
            send_item(c, $urandom_range(9) == 0);
         end
         3: begin
            send_u(rand_lead());
            send_u($urandom_range(1) ? rand_bmp() : rand_lead());
         end
         4: begin
            if ($urandom_range(1)) send_u(rand_lead());
            send_item(CH_BSLASH, 1'b0);
            send_item(CH_U, 1'b0);
            bad_pos = $urandom_range(3);
            for (int i = 0; i < 4; i++) begin
               if (i == bad_pos || $urandom_range(7) == 0) send_item(non_hex_byte(), 1'b0);
               else send_item(hex_char(4'($urandom)), 1'b0);
            end
         end
         5: begin
            if ($urandom_range(1)) send_u(rand_lead());
            send_item(CH_BSLASH, 1'b0);
            send_item(CH_U, 1'b0);
            n = $urandom_range(3);
            repeat (n) send_item(hex_char(4'($urandom)), 1'b0);
            send_item(8'($urandom), 1'b1);
         end
         6: begin
            send_item(CH_BSLASH, 1'b0);
            send_item(bad_letter(), $urandom_range(5) == 0);
         end
         7: begin
            if ($urandom_range(1)) send_item(NUL, 1'b0);
            else send_item(8'($urandom), 1'b1);
         end
         8: begin
            n = $urandom_range(6, 1);
            repeat (n) send_item(8'($urandom), $urandom_range(9) == 0);
         end
         default: begin
            send_u(rand_lead());
            if ($urandom_range(1)) send_item(CH_BSLASH, 1'b0);
            send_item(8'($urandom), 1'b1);
         end
      endcase
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.in_byte     = 8'h00;
      req_if.end_of_text = 1'b0;
      rsp_if.ready       = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, escapes, a surrogate pair, string end, unterminated text and bad escapes
      send_item(8'h01, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CH_BSLASH, 1'b0);
      send_item(CH_T, 1'b0);
      send_u(16'hD83D);
      send_u(16'hDE00);
      send_item(CH_QUOTE, 1'b0);
      send_item(NUL, 1'b0);
      send_item(8'hA5, 1'b1);
      send_item(CH_BSLASH, 1'b0);
      send_item(CH_X, 1'b0);
      send_item(CH_BSLASH, 1'b0);
      send_item(8'h00, 1'b1);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle = 16;
               recv_idle = 77;
            end
            1: begin
               send_idle = 77;
               recv_idle = 16;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         while (items_sent < (p + 1) * PHASE_ITEMS) send_segment();
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_bytes.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected results never arrived", $time, sb.expected_bytes.size());
      end

      $display("Covered %0d input bytes and %0d result bytes (%0d data).", sb.inputs_seen,
               sb.results_seen, sb.status_seen[ST_DATA]);
      $display("String ends %0d, unterminated %0d, bad escapes %0d, bad hex %0d; %0d errors.",
               sb.status_seen[ST_END], sb.status_seen[ST_UNTERM], sb.status_seen[ST_BADESC],
               sb.status_seen[ST_BADHEX], sb.errors);
      if (sb.errors == 0) begin
         $display("json_string_unescape_utf8_top test passed");
      end else begin
         $display("json_string_unescape_utf8_top test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/jsu_pkg.sv
src/jsu_if.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8_top.sv
dv/testbench.sv
